// File: rtl/jbsr_pkg.sv
// Package: shared widths, codes and types of the jitter buffer slot ring.
`default_nettype none
package jbsr_pkg;

   localparam int SLOTS_DEFAULT    = 16;
   localparam int CHANNELS_DEFAULT = 16;

   localparam int REQ_W     = 3;
   localparam int CHAN_W    = 4;
   localparam int LEN_W     = 17;
   localparam int STATUS_W  = 3;
   localparam int IDX_W     = 4;
   localparam int LEVEL_W   = 5;
   localparam int MODE_W    = 3;
   localparam int SEEN_W    = 5;
   localparam int THR_W     = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 17;

   localparam logic [LEN_W-1:0] SLOT_BYTES_RESET = LEN_W'(4096);
   localparam logic [LEN_W-1:0] SLOT_BYTES_MAX   = LEN_W'(65536);
   localparam logic [LEN_W-1:0] SLOT_BYTES_MIN   = LEN_W'(1);

   typedef enum logic [REQ_W-1:0] {
      REQ_ACQUIRE_WRITE = 3'd0,
      REQ_COMMIT        = 3'd1,
      REQ_ACQUIRE_READ  = 3'd2,
      REQ_RELEASE       = 3'd3,
      REQ_FLUSH         = 3'd4,
      REQ_PAUSE         = 3'd5,
      REQ_RESET         = 3'd6
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 3'd0,
      STATUS_WOULD_BLOCK = 3'd1,
      STATUS_FLUSHING    = 3'd2,
      STATUS_END         = 3'd3,
      STATUS_IGNORED     = 3'd4,
      STATUS_DROPPED     = 3'd5
   } status_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_STOPPED  = 3'd0,
      MODE_FILLING  = 3'd1,
      MODE_RUNNING  = 3'd2,
      MODE_FLUSHING = 3'd4,
      MODE_COMPLETE = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      SLOT_FREE  = 2'd0,
      SLOT_FILL  = 2'd1,
      SLOT_DRAIN = 2'd2,
      SLOT_READY = 2'd3
   } slot_state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILL_THRESHOLD = 1'd0,
      CSR_SLOT_BYTES     = 1'd1
   } csr_index_type;

endpackage
`default_nettype wire

// File: rtl/jbsr_if.sv
// Interfaces: request and reply channels of the jitter buffer slot ring.
`default_nettype none
interface jbsr_req_if import jbsr_pkg::*;;
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [CHAN_W-1:0] channel;
   logic [LEN_W-1:0]  length;
   logic              beat_flag;
   logic              pause_enable;

   modport source (output valid, req_type, channel, length, beat_flag, pause_enable,
                   input ready);
   modport sink   (input valid, req_type, channel, length, beat_flag, pause_enable,
                   output ready);
endinterface

interface jbsr_rsp_if import jbsr_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    slot_index;
   logic [LEN_W-1:0]    slot_length;
   logic                slot_beat;
   logic [LEVEL_W-1:0]  fill_level;
   logic [MODE_W-1:0]   buffer_mode;
   logic [SEEN_W-1:0]   channels_seen;
   logic                is_empty;

   modport source (output valid, status, slot_index, slot_length, slot_beat, fill_level,
                   buffer_mode, channels_seen, is_empty, input ready);
   modport sink   (input valid, status, slot_index, slot_length, slot_beat, fill_level,
                   buffer_mode, channels_seen, is_empty, output ready);
endinterface
`default_nettype wire

// File: rtl/jitter_buffer_slot_ring.sv
// Top level: slot ring state, request decode and registered reply.
//
// Serves one request per clock: a request is decoded against the slot table and
// counters in the cycle it is accepted, and its reply appears from the reply
// register on the next cycle. The reply register sets the rate; req ready stays
// high unless a reply is still waiting and rsp ready is low. Configuration
// writes take effect on the next request.
`default_nettype none
module jitter_buffer_slot_ring import jbsr_pkg::*; #(
   parameter int SLOTS    = SLOTS_DEFAULT,
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   jbsr_req_if.sink                  req_if,
   jbsr_rsp_if.source                rsp_if,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int PTR_W = $clog2(SLOTS);
   localparam int LVL_W = $clog2(SLOTS + 1);
   localparam int CH_W  = $clog2(CHANNELS + 1);
   localparam int CMP_W = (LVL_W > THR_W) ? LVL_W : THR_W;
   localparam int CS_W  = (CH_W > SEEN_W) ? CH_W : SEEN_W;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(SLOTS - 1);

   slot_state_type    slot_state_ff [SLOTS];
   slot_state_type    slot_state_in [SLOTS];
   logic [LEN_W-1:0]  slot_len_ff   [SLOTS];
   logic [CHAN_W-1:0] slot_chan_ff  [SLOTS];
   logic              slot_beat_ff  [SLOTS];

   logic [PTR_W-1:0]  write_ptr_ff, write_ptr_in;
   logic [PTR_W-1:0]  read_ptr_ff, read_ptr_in;
   logic [LVL_W-1:0]  level_ff, level_in;
   mode_type          mode_ff, mode_in;
   logic              paused_ff, paused_in;
   logic [CH_W-1:0]   chan_high_ff, chan_high_in;
   logic [THR_W-1:0]  thr_ff;
   logic [LEN_W-1:0]  slot_bytes_ff;

   logic                rsp_valid_ff;
   status_type          status_ff, status_in;
   logic [IDX_W-1:0]    index_ff, index_in;
   logic [LEN_W-1:0]    olen_ff, olen_in;
   logic                obeat_ff, obeat_in;
   logic                empty_ff, empty_in;

   logic              accept;
   logic              len_we, chan_we;
   logic [LEN_W-1:0]  cap, clamped_len;
   logic [CS_W-1:0]   seen;
   mode_type          mode_start;
   logic [PTR_W-1:0]  wp_next, rp_next;
   logic [CMP_W-1:0]  thr_cmp;
   logic [LVL_W-1:0]  level_dec;
   req_code_type      code;
   slot_state_type    ws, rs;

   assign accept        = req_if.valid && req_if.ready;
   assign req_if.ready  = !rsp_valid_ff || rsp_if.ready;
   assign code          = req_code_type'(req_if.req_type);
   assign ws            = slot_state_ff[write_ptr_ff];
   assign rs            = slot_state_ff[read_ptr_ff];
   assign wp_next       = (write_ptr_ff == LAST_SLOT) ? '0 : write_ptr_ff + 1'b1;
   assign rp_next       = (read_ptr_ff == LAST_SLOT) ? '0 : read_ptr_ff + 1'b1;
   assign thr_cmp       = CMP_W'(thr_ff);
   assign level_dec     = (level_ff != '0) ? level_ff - 1'b1 : level_ff;
   assign mode_start    = (mode_ff != MODE_STOPPED) ? mode_ff :
                          (thr_ff == '0) ? MODE_RUNNING : MODE_FILLING;

   always_comb begin
      cap = slot_bytes_ff;
      if (slot_bytes_ff == '0) begin
         cap = SLOT_BYTES_MIN;
      end else if (slot_bytes_ff > SLOT_BYTES_MAX) begin
         cap = SLOT_BYTES_MAX;
      end
      clamped_len = (req_if.length > cap) ? cap : req_if.length;
      seen = CS_W'(req_if.channel) + 1'b1;
      if (seen > CS_W'(CHANNELS)) begin
         seen = CS_W'(CHANNELS);
      end
   end

   always_comb begin
      slot_state_in = slot_state_ff;
      write_ptr_in  = write_ptr_ff;
      read_ptr_in   = read_ptr_ff;
      level_in      = level_ff;
      mode_in       = mode_ff;
      paused_in     = paused_ff;
      chan_high_in  = chan_high_ff;
      status_in     = STATUS_OK;
      index_in      = '0;
      olen_in       = '0;
      obeat_in      = 1'b0;
      len_we        = 1'b0;
      chan_we       = 1'b0;
      case (code)
         REQ_ACQUIRE_WRITE: begin
            if (CS_W'(chan_high_ff) < seen) begin
               chan_high_in = CH_W'(seen);
            end
            mode_in  = mode_start;
            index_in = IDX_W'(write_ptr_ff);
            if (mode_start == MODE_FLUSHING) begin
               status_in = STATUS_FLUSHING;
            end else if (ws != SLOT_FREE) begin
               status_in = STATUS_WOULD_BLOCK;
            end else begin
               slot_state_in[write_ptr_ff] = SLOT_FILL;
               chan_we = 1'b1;
            end
         end
         REQ_COMMIT: begin
            index_in = IDX_W'(write_ptr_ff);
            if (ws != SLOT_FILL) begin
               status_in = STATUS_IGNORED;
            end else if (req_if.length == '0) begin
               slot_state_in[write_ptr_ff] = SLOT_FREE;
               mode_in   = MODE_COMPLETE;
               status_in = STATUS_END;
            end else begin
               len_we = 1'b1;
               slot_state_in[write_ptr_ff] = SLOT_READY;
               if (level_ff != LVL_W'(SLOTS)) begin
                  level_in = level_ff + 1'b1;
               end
               write_ptr_in = wp_next;
               if (mode_ff == MODE_FILLING && CMP_W'(level_in) == thr_cmp) begin
                  mode_in = MODE_RUNNING;
               end
            end
         end
         REQ_ACQUIRE_READ: begin
            mode_in  = mode_start;
            index_in = IDX_W'(read_ptr_ff);
            if (rs == SLOT_FREE && mode_start == MODE_COMPLETE) begin
               status_in = STATUS_END;
            end else if (mode_start == MODE_FILLING || paused_ff || rs != SLOT_READY) begin
               status_in = STATUS_WOULD_BLOCK;
            end else if (slot_chan_ff[read_ptr_ff] != req_if.channel) begin
               slot_state_in[read_ptr_ff] = SLOT_FREE;
               level_in    = level_dec;
               read_ptr_in = rp_next;
               if (level_dec == '0 && thr_ff != '0) begin
                  mode_in = MODE_FILLING;
               end
               status_in = STATUS_DROPPED;
            end else begin
               slot_state_in[read_ptr_ff] = SLOT_DRAIN;
               olen_in  = slot_len_ff[read_ptr_ff];
               obeat_in = slot_beat_ff[read_ptr_ff];
            end
         end
         REQ_RELEASE: begin
            index_in = IDX_W'(read_ptr_ff);
            if (mode_ff == MODE_STOPPED || rs != SLOT_DRAIN) begin
               status_in = STATUS_IGNORED;
            end else begin
               slot_state_in[read_ptr_ff] = SLOT_FREE;
               level_in    = level_dec;
               read_ptr_in = rp_next;
               if (level_dec == '0 && thr_ff != '0) begin
                  mode_in = MODE_FILLING;
               end
            end
         end
         REQ_FLUSH: begin
            if (mode_ff == MODE_FLUSHING) begin
               status_in = STATUS_IGNORED;
            end else begin
               mode_in = MODE_FLUSHING;
            end
         end
         REQ_PAUSE: begin
            paused_in = req_if.pause_enable;
            if (mode_ff == MODE_FLUSHING && !req_if.pause_enable) begin
               mode_in = (CMP_W'(level_ff) > thr_cmp) ? MODE_RUNNING : MODE_FILLING;
            end
         end
         REQ_RESET: begin
            for (int i = 0; i < SLOTS; i++) begin
               slot_state_in[i] = SLOT_FREE;
            end
            write_ptr_in = '0;
            read_ptr_in  = '0;
            level_in     = '0;
            mode_in      = MODE_STOPPED;
         end
         default: begin
            status_in = STATUS_IGNORED;
         end
      endcase
      empty_in = (mode_in == MODE_FILLING) || (slot_state_in[read_ptr_in] != SLOT_READY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_state_ff[i] <= SLOT_FREE;
         end
         write_ptr_ff <= '0;
         read_ptr_ff  <= '0;
         level_ff     <= '0;
         mode_ff      <= MODE_STOPPED;
         paused_ff    <= 1'b0;
         chan_high_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            slot_state_ff <= slot_state_in;
            write_ptr_ff  <= write_ptr_in;
            read_ptr_ff   <= read_ptr_in;
            level_ff      <= level_in;
            mode_ff       <= mode_in;
            paused_ff     <= paused_in;
            chan_high_ff  <= chan_high_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= '0;
         slot_bytes_ff <= SLOT_BYTES_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FILL_THRESHOLD: thr_ff        <= THR_W'(csr_wdata);
            CSR_SLOT_BYTES:     slot_bytes_ff <= LEN_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && chan_we) begin
         slot_chan_ff[write_ptr_ff] <= req_if.channel;
      end
      if (accept && len_we) begin
         slot_len_ff[write_ptr_ff]  <= clamped_len;
         slot_beat_ff[write_ptr_ff] <= req_if.beat_flag;
      end
      if (accept) begin
         status_ff <= status_in;
         index_ff  <= index_in;
         olen_ff   <= olen_in;
         obeat_ff  <= obeat_in;
         empty_ff  <= empty_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = status_ff;
   assign rsp_if.slot_index    = index_ff;
   assign rsp_if.slot_length   = olen_ff;
   assign rsp_if.slot_beat     = obeat_ff;
   assign rsp_if.fill_level    = LEVEL_W'(level_ff);
   assign rsp_if.buffer_mode   = mode_ff;
   assign rsp_if.channels_seen = SEEN_W'(chan_high_ff);
   assign rsp_if.is_empty      = empty_ff;

endmodule
`default_nettype wire
